// ===== hdl/lav_pkg.sv =====
`default_nettype none

package lav_pkg;

    localparam int unsigned ACC_W   = 66;
    localparam int unsigned MAN_W   = 30;
    localparam int unsigned ROOT_W  = 31;
    localparam int unsigned QUO_W   = 31;
    localparam int unsigned SUM_W   = 63;
    localparam int unsigned NUM_W   = 61;
    localparam int unsigned ROT_SH  = 14;
    localparam int unsigned UNIT_SH = 30;

    localparam logic [1:0] COL_LAST = 2'd3;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    localparam logic signed [ACC_W-1:0] S32_MAX = ACC_W'(32'sh7fff_ffff);
    localparam logic signed [ACC_W-1:0] S32_MIN = -S32_MAX - ACC_W'(1);

    typedef struct packed {
        logic [2:0][31:0] u_rot;
        logic [2:0][31:0] v_rot;
        logic [2:0][31:0] n_rot;
        logic [2:0][31:0] xlat;
        logic             degen;
    } mat_t;

    // round half away from zero while shifting right
    function automatic logic signed [ACC_W-1:0] rnd_shift(
        input logic signed [ACC_W-1:0] x,
        input int unsigned             sh
    );
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] res;
        mag = x[ACC_W-1] ? ({ACC_W{1'b0}} - x) : x;
        res = (mag + (ACC_W'(1) << (sh - 1))) >> sh;
        return x[ACC_W-1] ? -$signed(res) : $signed(res);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        if (x > S32_MAX) begin
            return 32'sh7fff_ffff;
        end
        if (x < S32_MIN) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] rot_elem(input logic signed [ACC_W-1:0] x);
        return sat32(rnd_shift(x, ROT_SH));
    endfunction

endpackage

`default_nettype wire

// ===== hdl/lav_norm.sv =====
`default_nettype none

module lav_norm #(
    parameter int unsigned SIDE_W = 1
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 en,
    input  wire                 in_vld,
    input  wire  [2:0][63:0]    in_vec,
    input  wire  [SIDE_W-1:0]   in_side,
    output logic                out_vld,
    output logic [2:0][31:0]    out_vec,
    output logic                out_ok,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int unsigned SQ_N  = lav_pkg::ROOT_W;
    localparam int unsigned DV_N  = lav_pkg::QUO_W;
    localparam int unsigned MAN_W = lav_pkg::MAN_W;
    localparam int unsigned NST   = 5 + (SQ_N + 1) + (DV_N + 1) + 1;

    typedef struct packed {
        logic [2:0][MAN_W-1:0] m;
        logic [2:0]            neg;
        logic                  ok;
        logic [SIDE_W-1:0]     side;
    } car_t;

    logic [NST-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], in_vld};
        end
    end

    assign out_vld = vld_reg[NST-1];

    // magnitudes
    logic [2:0][63:0]    mag_a_reg;
    logic [2:0]          neg_a_reg;
    logic [SIDE_W-1:0]   side_a_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                neg_a_reg[i] <= in_vec[i][63];
                mag_a_reg[i] <= in_vec[i][63] ? (64'd0 - in_vec[i]) : in_vec[i];
            end
            side_a_reg <= in_side;
        end
    end

    // largest magnitude
    logic [63:0]         top_next;
    logic [63:0]         top_b_reg;
    logic [2:0][63:0]    mag_b_reg;
    logic [2:0]          neg_b_reg;
    logic [SIDE_W-1:0]   side_b_reg;

    always_comb begin
        top_next = mag_a_reg[0];
        if (mag_a_reg[1] > top_next) begin
            top_next = mag_a_reg[1];
        end
        if (mag_a_reg[2] > top_next) begin
            top_next = mag_a_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            top_b_reg  <= top_next;
            mag_b_reg  <= mag_a_reg;
            neg_b_reg  <= neg_a_reg;
            side_b_reg <= side_a_reg;
        end
    end

    // leading one position
    logic [5:0]          msb_next;
    logic [5:0]          msb_c_reg;
    logic                ok_c_reg;
    logic [2:0][63:0]    mag_c_reg;
    logic [2:0]          neg_c_reg;
    logic [SIDE_W-1:0]   side_c_reg;

    always_comb begin
        msb_next = '0;
        for (int k = 0; k < 64; k++) begin
            if (top_b_reg[k]) begin
                msb_next = 6'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            msb_c_reg  <= msb_next;
            ok_c_reg   <= |top_b_reg;
            mag_c_reg  <= mag_b_reg;
            neg_c_reg  <= neg_b_reg;
            side_c_reg <= side_b_reg;
        end
    end

    // common shift so the largest lies in [2^29, 2^30)
    car_t        car_d_next;
    car_t        car_d_reg;
    logic [63:0] shifted;

    always_comb begin
        shifted         = '0;
        car_d_next.neg  = neg_c_reg;
        car_d_next.ok   = ok_c_reg;
        car_d_next.side = side_c_reg;
        for (int i = 0; i < 3; i++) begin
            if (msb_c_reg > 6'(MAN_W - 1)) begin
                shifted = mag_c_reg[i] >> (msb_c_reg - 6'(MAN_W - 1));
            end else begin
                shifted = mag_c_reg[i] << (6'(MAN_W - 1) - msb_c_reg);
            end
            car_d_next.m[i] = shifted[MAN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            car_d_reg <= car_d_next;
        end
    end

    // squares
    logic [2:0][2*MAN_W-1:0] sq_e_reg;
    car_t                    car_e_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_e_reg[i] <= (2*MAN_W)'(car_d_reg.m[i]) * (2*MAN_W)'(car_d_reg.m[i]);
            end
            car_e_reg <= car_d_reg;
        end
    end

    // square root, one result bit per stage
    logic [lav_pkg::SUM_W-1:0] rem_reg  [SQ_N+1];
    logic [SQ_N-1:0]           root_reg [SQ_N+1];
    car_t                      sqc_reg  [SQ_N+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= lav_pkg::SUM_W'(sq_e_reg[0]) + lav_pkg::SUM_W'(sq_e_reg[1])
                         + lav_pkg::SUM_W'(sq_e_reg[2]);
            root_reg[0] <= '0;
            sqc_reg[0]  <= car_e_reg;
        end
    end

    for (genvar k = 1; k <= SQ_N; k++) begin : g_sqrt
        localparam int unsigned B = SQ_N - k;
        logic [lav_pkg::SUM_W-1:0] trial;

        assign trial = (lav_pkg::SUM_W'(root_reg[k-1]) << (B + 1))
                     + (lav_pkg::SUM_W'(1) << (2 * B));

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_reg[k-1] >= trial) begin
                    rem_reg[k]  <= rem_reg[k-1] - trial;
                    root_reg[k] <= root_reg[k-1] | (SQ_N'(1) << B);
                end else begin
                    rem_reg[k]  <= rem_reg[k-1];
                    root_reg[k] <= root_reg[k-1];
                end
                sqc_reg[k] <= sqc_reg[k-1];
            end
        end
    end

    // division numerators
    localparam int unsigned NUM_W = lav_pkg::NUM_W;

    logic [2:0][NUM_W-1:0] num_next;
    logic [2:0][NUM_W-1:0] num_reg  [DV_N+1];
    logic [2:0][31:0]      drem_reg [DV_N+1];
    logic [2:0][DV_N-1:0]  quo_reg  [DV_N+1];
    logic [SQ_N-1:0]       dlen_reg [DV_N+1];
    car_t                  dvc_reg  [DV_N+1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num_next[i] = (NUM_W'(sqc_reg[SQ_N].m[i]) << lav_pkg::UNIT_SH)
                        + NUM_W'(root_reg[SQ_N] >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                drem_reg[0][i] <= 32'(num_next[i][NUM_W-1:DV_N]);
            end
            num_reg[0]  <= num_next;
            quo_reg[0]  <= '0;
            dlen_reg[0] <= root_reg[SQ_N];
            dvc_reg[0]  <= sqc_reg[SQ_N];
        end
    end

    // restoring division, one quotient bit per stage, three lanes
    for (genvar k = 1; k <= DV_N; k++) begin : g_div
        localparam int unsigned B = DV_N - k;
        logic [2:0][31:0] trial;
        logic [2:0]       ge;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                trial[i] = {drem_reg[k-1][i][30:0], num_reg[k-1][i][B]};
                ge[i]    = trial[i] >= {1'b0, dlen_reg[k-1]};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    drem_reg[k][i] <= ge[i] ? (trial[i] - {1'b0, dlen_reg[k-1]}) : trial[i];
                    quo_reg[k][i]  <= quo_reg[k-1][i] | (DV_N'(ge[i]) << B);
                end
                num_reg[k]  <= num_reg[k-1];
                dlen_reg[k] <= dlen_reg[k-1];
                dvc_reg[k]  <= dvc_reg[k-1];
            end
        end
    end

    // sign and zero-length handling
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (!dvc_reg[DV_N].ok) begin
                    out_vec[i] <= '0;
                end else if (dvc_reg[DV_N].neg[i]) begin
                    out_vec[i] <= 32'd0 - 32'(quo_reg[DV_N][i]);
                end else begin
                    out_vec[i] <= 32'(quo_reg[DV_N][i]);
                end
            end
            out_ok   <= dvc_reg[DV_N].ok;
            out_side <= dvc_reg[DV_N].side;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lav_cross.sv =====
`default_nettype none

module lav_cross #(
    parameter int unsigned SIDE_W = 1
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 en,
    input  wire                 in_vld,
    input  wire  [2:0][31:0]    in_a,
    input  wire  [2:0][31:0]    in_b,
    input  wire  [SIDE_W-1:0]   in_side,
    output logic                out_vld,
    output logic [2:0][63:0]    out_vec,
    output logic [SIDE_W-1:0]   out_side
);

    logic [1:0]        vld_reg;
    logic [5:0][63:0]  prod_reg;
    logic [SIDE_W-1:0] side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[0], in_vld};
        end
    end

    assign out_vld = vld_reg[1];

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg[0] <= $signed(in_a[1]) * $signed(in_b[2]);
            prod_reg[1] <= $signed(in_a[2]) * $signed(in_b[1]);
            prod_reg[2] <= $signed(in_a[2]) * $signed(in_b[0]);
            prod_reg[3] <= $signed(in_a[0]) * $signed(in_b[2]);
            prod_reg[4] <= $signed(in_a[0]) * $signed(in_b[1]);
            prod_reg[5] <= $signed(in_a[1]) * $signed(in_b[0]);
            side_reg    <= in_side;
            for (int i = 0; i < 3; i++) begin
                out_vec[i] <= prod_reg[2*i] - prod_reg[2*i+1];
            end
            out_side <= side_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lav_ser.sv =====
`default_nettype none

module lav_ser (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   ld,
    input  lav_pkg::mat_t         mat,
    output logic                  free,
    output logic                  o_valid,
    input  wire                   o_ready,
    output logic [1:0]            o_column,
    output logic signed [31:0]    o_row0,
    output logic signed [31:0]    o_row1,
    output logic signed [31:0]    o_row2,
    output logic signed [31:0]    o_row3,
    output logic                  o_last,
    output logic                  o_degen
);

    lav_pkg::mat_t mat_reg;
    logic [1:0]    col_reg;
    logic          vld_reg;

    assign free = !vld_reg || (o_ready && col_reg == lav_pkg::COL_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            col_reg <= '0;
        end else if (ld) begin
            vld_reg <= 1'b1;
            col_reg <= '0;
        end else if (vld_reg && o_ready) begin
            if (col_reg == lav_pkg::COL_LAST) begin
                vld_reg <= 1'b0;
            end
            col_reg <= col_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            mat_reg <= mat;
        end
    end

    always_comb begin
        unique case (col_reg)
            2'd0: begin
                o_row0 = mat_reg.u_rot[0];
                o_row1 = mat_reg.v_rot[0];
                o_row2 = mat_reg.n_rot[0];
                o_row3 = '0;
            end
            2'd1: begin
                o_row0 = mat_reg.u_rot[1];
                o_row1 = mat_reg.v_rot[1];
                o_row2 = mat_reg.n_rot[1];
                o_row3 = '0;
            end
            2'd2: begin
                o_row0 = mat_reg.u_rot[2];
                o_row1 = mat_reg.v_rot[2];
                o_row2 = mat_reg.n_rot[2];
                o_row3 = '0;
            end
            default: begin
                o_row0 = mat_reg.xlat[0];
                o_row1 = mat_reg.xlat[1];
                o_row2 = mat_reg.xlat[2];
                o_row3 = lav_pkg::Q_ONE;
            end
        endcase
    end

    assign o_valid  = vld_reg;
    assign o_column = col_reg;
    assign o_last   = col_reg == lav_pkg::COL_LAST;
    assign o_degen  = mat_reg.degen;

endmodule

`default_nettype wire

// ===== hdl/look_at_view_matrix.sv =====
// Output: each transaction leaves as four columns in column order, and the serializer
// moves to the next column whenever m_ready is high; it takes a new transaction only
// once its last column is accepted. The 149-stage datapath (two 70-stage normalizers)
// can take one transaction per cycle while the serializer does not stall it.
// Reset: aresetn, synchronous active low, clears all valid bits and the column counter.
`default_nettype none

module look_at_view_matrix (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire signed [31:0]   s_eye_x,
    input  wire signed [31:0]   s_eye_y,
    input  wire signed [31:0]   s_eye_z,
    input  wire signed [31:0]   s_target_x,
    input  wire signed [31:0]   s_target_y,
    input  wire signed [31:0]   s_target_z,
    input  wire signed [31:0]   s_upward_x,
    input  wire signed [31:0]   s_upward_y,
    input  wire signed [31:0]   s_upward_z,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [1:0]          m_column_index,
    output logic signed [31:0]  m_elem_row0,
    output logic signed [31:0]  m_elem_row1,
    output logic signed [31:0]  m_elem_row2,
    output logic signed [31:0]  m_elem_row3,
    output logic                m_last_column,
    output logic                m_degenerate
);

    localparam int unsigned ACC_W = lav_pkg::ACC_W;

    logic en;
    logic ser_free;
    logic t_vld_reg;

    assign en      = ser_free || !t_vld_reg;
    assign s_ready = en;

    // direction = target - eye
    logic             t0_vld_reg;
    logic [2:0][32:0] t0_d_reg;
    logic [2:0][31:0] t0_eye_reg;
    logic [2:0][31:0] t0_up_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t0_vld_reg <= 1'b0;
        end else if (en) begin
            t0_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t0_d_reg[0] <= {s_target_x[31], s_target_x} - {s_eye_x[31], s_eye_x};
            t0_d_reg[1] <= {s_target_y[31], s_target_y} - {s_eye_y[31], s_eye_y};
            t0_d_reg[2] <= {s_target_z[31], s_target_z} - {s_eye_z[31], s_eye_z};
            t0_eye_reg  <= {s_eye_z, s_eye_y, s_eye_x};
            t0_up_reg   <= {s_upward_z, s_upward_y, s_upward_x};
        end
    end

    // normalize direction
    logic [2:0][63:0] d64;
    logic [191:0]     n1_side_in;
    logic             n1_vld;
    logic [2:0][31:0] n1_vec;
    logic             n1_ok;
    logic [191:0]     n1_side;

    for (genvar i = 0; i < 3; i++) begin : g_d64
        assign d64[i] = 64'($signed(t0_d_reg[i]));
    end

    assign n1_side_in = {t0_up_reg, t0_eye_reg};

    lav_norm #(.SIDE_W(192)) u_norm_n (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (t0_vld_reg),
        .in_vec   (d64),
        .in_side  (n1_side_in),
        .out_vld  (n1_vld),
        .out_vec  (n1_vec),
        .out_ok   (n1_ok),
        .out_side (n1_side)
    );

    // side = n x up
    logic [192:0]     c1_side_in;
    logic             c1_vld;
    logic [2:0][63:0] c1_vec;
    logic [192:0]     c1_side;

    assign c1_side_in = {n1_ok, n1_vec, n1_side[95:0]};

    lav_cross #(.SIDE_W(193)) u_cross_u (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (n1_vld),
        .in_a     (n1_vec),
        .in_b     (n1_side[191:96]),
        .in_side  (c1_side_in),
        .out_vld  (c1_vld),
        .out_vec  (c1_vec),
        .out_side (c1_side)
    );

    logic             n2_vld;
    logic [2:0][31:0] n2_vec;
    logic             n2_ok;
    logic [192:0]     n2_side;

    lav_norm #(.SIDE_W(193)) u_norm_u (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (c1_vld),
        .in_vec   (c1_vec),
        .in_side  (c1_side),
        .out_vld  (n2_vld),
        .out_vec  (n2_vec),
        .out_ok   (n2_ok),
        .out_side (n2_side)
    );

    // true up = u x n
    logic [288:0]     c2_side_in;
    logic             c2_vld;
    logic [2:0][63:0] c2_vec;
    logic [288:0]     c2_side;

    assign c2_side_in = {!n2_side[192] || !n2_ok, n2_vec, n2_side[191:0]};

    lav_cross #(.SIDE_W(289)) u_cross_v (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (n2_vld),
        .in_a     (n2_vec),
        .in_b     (n2_side[191:96]),
        .in_side  (c2_side_in),
        .out_vld  (c2_vld),
        .out_vec  (c2_vec),
        .out_side (c2_side)
    );

    // tail: v rounding, products, sums, final rounding
    logic [2:0]       tv_reg;
    logic [2:0][32:0] v_r_reg;
    logic [288:0]     side_r_reg;

    logic [2:0][ACC_W-1:0] ue_p_reg;
    logic [2:0][ACC_W-1:0] ve_p_reg;
    logic [2:0][ACC_W-1:0] ne_p_reg;
    lav_pkg::mat_t         mat_p_reg;
    logic [ACC_W-1:0]      sum_s_reg [3];
    lav_pkg::mat_t         mat_s_reg;
    lav_pkg::mat_t         mat_t_reg;
    logic signed [ACC_W-1:0] rnd_v [3];

    logic [2:0][31:0] u_r;
    logic [2:0][31:0] n_r;
    logic [2:0][31:0] e_r;

    assign u_r = side_r_reg[287:192];
    assign n_r = side_r_reg[191:96];
    assign e_r = side_r_reg[95:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tv_reg    <= '0;
            t_vld_reg <= 1'b0;
        end else if (en) begin
            tv_reg    <= {tv_reg[1:0], c2_vld};
            t_vld_reg <= tv_reg[2];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rnd_v[i] = lav_pkg::rnd_shift($signed(c2_vec[i]), lav_pkg::UNIT_SH);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                v_r_reg[i] <= rnd_v[i][32:0];
            end
            side_r_reg <= c2_side;

            for (int i = 0; i < 3; i++) begin
                ue_p_reg[i] <= $signed(u_r[i]) * $signed(e_r[i]);
                ve_p_reg[i] <= $signed(v_r_reg[i]) * $signed(e_r[i]);
                ne_p_reg[i] <= $signed(n_r[i]) * $signed(e_r[i]);
                mat_p_reg.u_rot[i] <= lav_pkg::rot_elem($signed(u_r[i]));
                mat_p_reg.v_rot[i] <= lav_pkg::rot_elem($signed(v_r_reg[i]));
                mat_p_reg.n_rot[i] <= lav_pkg::rot_elem(-$signed(ACC_W'($signed(n_r[i]))));
            end
            mat_p_reg.xlat  <= '0;
            mat_p_reg.degen <= side_r_reg[288];

            sum_s_reg[0] <= ue_p_reg[0] + ue_p_reg[1] + ue_p_reg[2];
            sum_s_reg[1] <= ve_p_reg[0] + ve_p_reg[1] + ve_p_reg[2];
            sum_s_reg[2] <= ne_p_reg[0] + ne_p_reg[1] + ne_p_reg[2];
            mat_s_reg    <= mat_p_reg;

            mat_t_reg.u_rot <= mat_s_reg.u_rot;
            mat_t_reg.v_rot <= mat_s_reg.v_rot;
            mat_t_reg.n_rot <= mat_s_reg.n_rot;
            mat_t_reg.degen <= mat_s_reg.degen;
            mat_t_reg.xlat[0] <= lav_pkg::sat32(-lav_pkg::rnd_shift($signed(sum_s_reg[0]),
                                                                   lav_pkg::UNIT_SH));
            mat_t_reg.xlat[1] <= lav_pkg::sat32(-lav_pkg::rnd_shift($signed(sum_s_reg[1]),
                                                                   lav_pkg::UNIT_SH));
            mat_t_reg.xlat[2] <= lav_pkg::sat32(lav_pkg::rnd_shift($signed(sum_s_reg[2]),
                                                                  lav_pkg::UNIT_SH));
        end
    end

    lav_ser u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ld       (en && t_vld_reg),
        .mat      (mat_t_reg),
        .free     (ser_free),
        .o_valid  (m_valid),
        .o_ready  (m_ready),
        .o_column (m_column_index),
        .o_row0   (m_elem_row0),
        .o_row1   (m_elem_row1),
        .o_row2   (m_elem_row2),
        .o_row3   (m_elem_row3),
        .o_last   (m_last_column),
        .o_degen  (m_degenerate)
    );

`ifndef NO_ASSERTIONS
    a_col_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_column_index != lav_pkg::COL_LAST
        |=> m_valid && m_column_index == $past(m_column_index) + 2'd1)
        else $error("column sequence broken");

    a_col_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_column |=> !m_valid || m_column_index == 2'd0)
        else $error("new transaction does not start at column 0");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with output idle");

    a_unit_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_column |-> m_elem_row3 == lav_pkg::Q_ONE)
        else $error("translation column row 3 not 1.0");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic signed [31:0] eye [3];
        logic signed [31:0] tgt [3];
        logic signed [31:0] up [3];
    } camera_t;

    typedef struct {
        logic [1:0]         col;
        logic signed [31:0] row [4];
        logic               last;
        logic               degen;
    } column_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_eye_x = '0, s_eye_y = '0, s_eye_z = '0;
    logic signed [31:0] s_target_x = '0, s_target_y = '0, s_target_z = '0;
    logic signed [31:0] s_upward_x = '0, s_upward_y = '0, s_upward_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_column_index;
    logic signed [31:0] m_elem_row0, m_elem_row1, m_elem_row2, m_elem_row3;
    logic m_last_column, m_degenerate;

    look_at_view_matrix dut (.*);

    camera_t pending_cams [$];
    column_t expected_cols [$];
    int errors = 0;
    int fed = 0;
    bit sender_pause = 0;
    logic s_ready_q = 1'b0;

    initial forever #5 aclk = ~aclk;

    function automatic longint unsigned mag(input longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint rnd_away(input longint x, input int sh);
        longint unsigned m;
        m = (mag(x) + (64'd1 << (sh - 1))) >> sh;
        return x < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit to_unit(input longint c [3], output longint o [3]);
        longint unsigned m [3];
        longint unsigned top, sum, len, q;
        int r, l;
        r = 0;
        l = 0;
        for (int i = 0; i < 3; i++) m[i] = mag(c[i]);
        top = m[0];
        if (m[1] > top) top = m[1];
        if (m[2] > top) top = m[2];
        if (top == 0) begin
            for (int i = 0; i < 3; i++) o[i] = 0;
            return 0;
        end
        while ((top >> r) >= (64'd1 << 30)) r++;
        while ((top << l) < (64'd1 << 29)) l++;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (m[i] >> r) << l;
            sum += m[i] * m[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 30) + (len >> 1)) / len;
            o[i] = c[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint x);
        if (x > 64'sd2147483647) return 32'sh7fff_ffff;
        if (x < -64'sd2147483648) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    // one camera -> four view matrix columns
    task automatic predict_view(input camera_t c);
        longint e [3], d [3], n [3], cu [3], u [3], v [3], tr [3], up [3];
        bit okn, oku;
        column_t col;
        for (int i = 0; i < 3; i++) begin
            e[i] = c.eye[i];
            up[i] = c.up[i];
            d[i] = longint'(c.tgt[i]) - e[i];
        end
        okn = to_unit(d, n);
        cu[0] = n[1] * up[2] - n[2] * up[1];
        cu[1] = n[2] * up[0] - n[0] * up[2];
        cu[2] = n[0] * up[1] - n[1] * up[0];
        oku = to_unit(cu, u);
        v[0] = rnd_away(u[1] * n[2] - u[2] * n[1], 30);
        v[1] = rnd_away(u[2] * n[0] - u[0] * n[2], 30);
        v[2] = rnd_away(u[0] * n[1] - u[1] * n[0], 30);
        tr[0] = -(u[0] * e[0] + u[1] * e[1] + u[2] * e[2]);
        tr[1] = -(v[0] * e[0] + v[1] * e[1] + v[2] * e[2]);
        tr[2] = n[0] * e[0] + n[1] * e[1] + n[2] * e[2];
        for (int k = 0; k < 4; k++) begin
            col.col = k[1:0];
            if (k < 3) begin
                col.row[0] = clamp32(rnd_away(u[k], lav_pkg::ROT_SH));
                col.row[1] = clamp32(rnd_away(v[k], lav_pkg::ROT_SH));
                col.row[2] = clamp32(rnd_away(-n[k], lav_pkg::ROT_SH));
                col.row[3] = '0;
            end else begin
                for (int j = 0; j < 3; j++) col.row[j] = clamp32(rnd_away(tr[j], 30));
                col.row[3] = lav_pkg::Q_ONE;
            end
            col.last = (k == 3);
            col.degen = !(okn && oku);
            expected_cols.push_back(col);
        end
    endtask

    function automatic logic signed [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
            2: return $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
            default: return $signed($urandom_range(0, 511)) - 256;
        endcase
    endfunction

    function automatic camera_t rand_camera();
        camera_t c;
        int mode;
        mode = $urandom_range(0, 3);
        for (int i = 0; i < 3; i++) begin
            c.eye[i] = rand_coord(mode);
            c.tgt[i] = rand_coord(mode);
            c.up[i] = rand_coord($urandom_range(0, 3));
        end
        case ($urandom_range(0, 15))
            0: c.tgt = c.eye;
            1: for (int i = 0; i < 3; i++) c.up[i] = c.tgt[i] - c.eye[i];
            2: c.up = '{0, 0, 0};
            default: ;
        endcase
        return c;
    endfunction

    function automatic camera_t make_cam(input logic signed [31:0] ex, ey, ez, tx, ty, tz,
                                         ux, uy, uz);
        camera_t c;
        c.eye = '{ex, ey, ez};
        c.tgt = '{tx, ty, tz};
        c.up = '{ux, uy, uz};
        return c;
    endfunction

    localparam logic signed [31:0] MX = 32'sh7fff_ffff;
    localparam logic signed [31:0] MN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;

    initial begin
        pending_cams.push_back(make_cam(0, 0, 0, 0, 0, -ONE, 0, ONE, 0));
        pending_cams.push_back(make_cam(0, 0, 5*ONE, 0, 0, 0, 0, ONE, 0));
        pending_cams.push_back(make_cam(ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE, 0, ONE, 0));
        pending_cams.push_back(make_cam(0, 0, 0, 0, ONE, 0, 0, ONE, 0));
        pending_cams.push_back(make_cam(0, 0, 0, ONE, 0, 0, 0, 0, 0));
        pending_cams.push_back(make_cam(MN, MN, MN, MX, MX, MX, MX, MN, MX));
        pending_cams.push_back(make_cam(MX, MX, MX, MN, MN, MN, MN, MX, MN));
        pending_cams.push_back(make_cam(MX, MN, MX, 0, 0, 0, 0, ONE, 0));
        pending_cams.push_back(make_cam(MN, MN, MN, MN, MN, MN + 1, MN, MN, MN));
        pending_cams.push_back(make_cam(-1, -1, -1, 1, 1, 1, 1, -1, 0));
        pending_cams.push_back(make_cam(MX, MX, MN, MN, MX, MX, 1, 0, 0));
        pending_cams.push_back(make_cam(32'sh1234_5678, -32'sh0765_4321, 32'sh7000_0000,
                                        -32'sh2000_0000, 32'sh0abc_def0, -32'sh0000_0001,
                                        32'sh5555_5555, -32'sh2aaa_aaaa, 32'sh0000_ffff));
        for (int i = 0; i < 350; i++) pending_cams.push_back(rand_camera());
    end

    // sender
    int gap = 0;
    always @(negedge aclk) begin
        if (aresetn && !(s_valid && !s_ready_q)) begin
            if (s_ready_q) begin
                gap = $urandom_range(0, 3);
                if ($urandom_range(0, 3) == 0) gap = 0;
            end
            if (fed == 150 && !sender_pause) begin
                s_valid <= 1'b0;
                if (expected_cols.size() == 0) sender_pause <= 1'b1;
            end else if (gap > 0) begin
                gap--;
                s_valid <= 1'b0;
            end else if (pending_cams.size() != 0) begin
                camera_t c;
                c = pending_cams.pop_front();
                {s_eye_x, s_eye_y, s_eye_z} <= {c.eye[0], c.eye[1], c.eye[2]};
                {s_target_x, s_target_y, s_target_z} <= {c.tgt[0], c.tgt[1], c.tgt[2]};
                {s_upward_x, s_upward_y, s_upward_z} <= {c.up[0], c.up[1], c.up[2]};
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // handshake as seen at the last rising edge
    always @(posedge aclk) begin
        s_ready_q <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            camera_t c;
            c = make_cam(s_eye_x, s_eye_y, s_eye_z, s_target_x, s_target_y, s_target_z,
                         s_upward_x, s_upward_y, s_upward_z);
            predict_view(c);
            fed <= fed + 1;
        end
    end

    // receiver
    int stall = 0;
    int long_hold = 600;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (fed >= 40 && long_hold > 0) begin
                long_hold--;
                m_ready <= 1'b0;
            end else if (m_valid && m_ready) begin
                stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
                m_ready <= (stall == 0);
            end else if (stall > 0) begin
                stall--;
                m_ready <= (stall == 0);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            column_t want;
            if (expected_cols.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected transaction col=%0d", m_column_index);
            end else begin
                want = expected_cols.pop_front();
                if (want.col !== m_column_index || want.row[0] !== m_elem_row0
                    || want.row[1] !== m_elem_row1 || want.row[2] !== m_elem_row2
                    || want.row[3] !== m_elem_row3 || want.last !== m_last_column
                    || want.degen !== m_degenerate) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %0d %h %h %h %h %b %b got %0d %h %h %h %h %b %b",
                                 want.col, want.row[0], want.row[1], want.row[2], want.row[3],
                                 want.last, want.degen, m_column_index, m_elem_row0,
                                 m_elem_row1, m_elem_row2, m_elem_row3, m_last_column,
                                 m_degenerate);
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        wait (pending_cams.size() == 0 && !s_valid);
        wait (expected_cols.size() == 0);
        repeat (300) @(posedge aclk);
        if (errors == 0 && expected_cols.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_top: done, errors");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/lav_pkg.sv
hdl/lav_norm.sv
hdl/lav_cross.sv
hdl/lav_ser.sv
hdl/look_at_view_matrix.sv
sim/tb_top.sv
